// ===== design/assert_macros.svh =====
// assertion helpers shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// condition must hold at every edge out of reset
`define AST_ALWAYS(label, clk, rst_n, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("assertion failed");

// consequent must hold in the same cycle as the antecedent
`define AST_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// consequent must hold in the cycle after the antecedent
`define AST_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define AST_ALWAYS(label, clk, rst_n, expr)
`define AST_IMPLIES(label, clk, rst_n, ante, cons)
`define AST_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== design/hatfl_pkg.sv =====
`timescale 1ns / 1ps

package hatfl_pkg;

  localparam int QUERY_W     = 64;
  localparam int BYTE_W      = 8;
  localparam int STATUS_W    = 4;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [BYTE_W-1:0] CHAR_NEWLINE = 8'h0a;
  localparam logic [BYTE_W-1:0] CHAR_ZERO    = 8'h30;
  localparam logic [BYTE_W-1:0] CHAR_NINE    = 8'h39;
  localparam logic [BYTE_W-1:0] CHAR_A       = 8'h61;
  localparam logic [BYTE_W-1:0] CHAR_F       = 8'h66;
  localparam logic [BYTE_W-1:0] HEX_TEN      = 8'd10;

  typedef enum logic [1:0] {
    OP_BYTE   = 2'd0,
    OP_EOF    = 2'd1,
    OP_LOOKUP = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_TAKEN    = 4'd0,
    ST_COMMIT   = 4'd1,
    ST_FOUND    = 4'd2,
    ST_NOTFOUND = 4'd3,
    ST_SHORT    = 4'd4,
    ST_BADDIGIT = 4'd5,
    ST_LONG     = 4'd6,
    ST_FULL     = 4'd7,
    ST_REFUSED  = 4'd8
  } status_t;

  // classified item as it sits in the queue
  typedef struct packed {
    op_t                op;
    logic               is_newline;
    logic               digit_ok;
    logic [3:0]         digit;
    logic [QUERY_W-1:0] query;
  } item_t;

endpackage

// ===== design/hatfl_front.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"

module hatfl_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    in_action,
  input  logic [hatfl_pkg::BYTE_W-1:0]  in_text_byte,
  input  logic [hatfl_pkg::QUERY_W-1:0] in_query_address,
  output logic                          q_valid,
  output hatfl_pkg::item_t              q_item,
  input  logic                          q_pop
);

  localparam int PTR_W = (hatfl_pkg::QUEUE_DEPTH > 1) ? $clog2(hatfl_pkg::QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(hatfl_pkg::QUEUE_DEPTH + 1);

  hatfl_pkg::item_t  store_r [hatfl_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  hatfl_pkg::item_t  cls;
  logic              push;

  // classify the incoming byte once, so the back end only acts
  always_comb begin
    cls            = '0;
    cls.op         = hatfl_pkg::op_t'(in_action);
    cls.query      = in_query_address;
    cls.is_newline = (in_text_byte == hatfl_pkg::CHAR_NEWLINE);
    if (in_text_byte >= hatfl_pkg::CHAR_ZERO && in_text_byte <= hatfl_pkg::CHAR_NINE) begin
      cls.digit_ok = 1'b1;
      cls.digit    = 4'(in_text_byte - hatfl_pkg::CHAR_ZERO);
    end else if (in_text_byte >= hatfl_pkg::CHAR_A && in_text_byte <= hatfl_pkg::CHAR_F) begin
      cls.digit_ok = 1'b1;
      cls.digit    = 4'(in_text_byte - hatfl_pkg::CHAR_A + hatfl_pkg::HEX_TEN);
    end
  end

  assign in_stall = (cnt_r == CNT_W'(hatfl_pkg::QUEUE_DEPTH));
  assign push     = in_valid && !in_stall;
  assign q_valid  = (cnt_r != '0);
  assign q_item   = store_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(hatfl_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (q_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(hatfl_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !q_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!push && q_pop) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      store_r[wr_ptr_r] <= cls;
    end
  end

  `AST_ALWAYS(a_cnt_bound, clk, rst_n, cnt_r <= CNT_W'(hatfl_pkg::QUEUE_DEPTH))
  `AST_IMPLIES(a_pop_nonempty, clk, rst_n, q_pop, cnt_r != '0)
  `AST_NEXT(a_push_seen, clk, rst_n, push && !q_pop, cnt_r != '0)

endmodule

// ===== design/hatfl_back.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"

module hatfl_back #(
  parameter int TABLE_DEPTH    = 8192,
  parameter int LINE_LIMIT     = 128,
  parameter int ADDRESS_DIGITS = 8
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               q_valid,
  input  hatfl_pkg::item_t                   q_item,
  output logic                               q_pop,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [hatfl_pkg::STATUS_W-1:0]     out_status,
  output logic [$clog2(TABLE_DEPTH)-1:0]     out_row_index,
  output logic [$clog2(TABLE_DEPTH+1)-1:0]   out_rows_loaded
);

  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int LEN_W = $clog2(LINE_LIMIT + 1);
  localparam int ADR_W = 4 * ADDRESS_DIGITS;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SEARCH,
    S_DONE
  } state_t;

  logic [ADR_W-1:0] table_mem [TABLE_DEPTH];
  logic [ADR_W-1:0] rdata_r;

  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [LEN_W-1:0]   len_r, len_nxt;
  logic [ADR_W-1:0]   partial_r, partial_nxt;
  logic               bad_r, bad_nxt;
  logic               closed_r, closed_nxt;
  logic               err_r, err_nxt;
  logic [CNT_W-1:0]   lo_r, lo_nxt;
  logic [CNT_W-1:0]   hi_r, hi_nxt;
  logic [IDX_W-1:0]   mid_r, mid_nxt;
  logic [hatfl_pkg::QUERY_W-1:0] query_r, query_nxt;
  hatfl_pkg::status_t res_status_r, res_status_nxt;
  logic [IDX_W-1:0]   res_row_r, res_row_nxt;
  logic               out_valid_r, out_valid_nxt;
  hatfl_pkg::status_t out_status_r, out_status_nxt;
  logic [IDX_W-1:0]   out_row_r, out_row_nxt;
  logic [CNT_W-1:0]   out_rows_r, out_rows_nxt;

  logic               slot_free;
  logic               we;
  logic [IDX_W-1:0]   rd_addr;
  logic               rd_issue;
  logic [CNT_W:0]     start_sum;
  logic [CNT_W:0]     step_sum;
  logic [CNT_W-1:0]   start_half;
  logic [CNT_W-1:0]   step_half;
  logic               lt;
  logic [CNT_W-1:0]   lo_n, hi_n, below_lo;
  logic [LEN_W-1:0]   len_inc;
  logic [ADR_W+3:0]   shifted;
  hatfl_pkg::status_t commit_st;
  logic               do_commit;
  logic               imm_load;
  hatfl_pkg::status_t imm_status;
  logic [IDX_W-1:0]   imm_row;

  assign slot_free = !out_valid_r || !out_stall;

  // first probe of a fresh search: left 0, right rows-1
  assign start_sum  = {1'b0, count_r} - 1'b1;
  assign start_half = start_sum[CNT_W:1];

  // one probe: data of mid_r came back this cycle
  assign lt       = (query_r < hatfl_pkg::QUERY_W'(rdata_r));
  assign lo_n     = lt ? lo_r : CNT_W'(mid_r) + 1'b1;
  assign hi_n     = lt ? CNT_W'(mid_r) : hi_r;
  assign step_sum = {1'b0, lo_n} + {1'b0, hi_n} - 1'b1;
  assign step_half = step_sum[CNT_W:1];
  assign below_lo = lo_n - 1'b1;

  assign len_inc = len_r + 1'b1;
  assign shifted = {partial_r, q_item.digit};

  // errors at commit: short line, then bad digit, then full
  always_comb begin
    if (len_r < LEN_W'(ADDRESS_DIGITS)) begin
      commit_st = hatfl_pkg::ST_SHORT;
    end else if (bad_r) begin
      commit_st = hatfl_pkg::ST_BADDIGIT;
    end else if (count_r == CNT_W'(TABLE_DEPTH)) begin
      commit_st = hatfl_pkg::ST_FULL;
    end else begin
      commit_st = hatfl_pkg::ST_COMMIT;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    len_nxt        = len_r;
    partial_nxt    = partial_r;
    bad_nxt        = bad_r;
    closed_nxt     = closed_r;
    err_nxt        = err_r;
    lo_nxt         = lo_r;
    hi_nxt         = hi_r;
    mid_nxt        = mid_r;
    query_nxt      = query_r;
    res_status_nxt = res_status_r;
    res_row_nxt    = res_row_r;
    q_pop          = 1'b0;
    we             = 1'b0;
    rd_addr        = start_half[IDX_W-1:0];
    rd_issue       = 1'b0;
    do_commit      = 1'b0;
    imm_load       = 1'b0;
    imm_status     = hatfl_pkg::ST_TAKEN;
    imm_row        = '0;

    unique case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          if (q_item.op == hatfl_pkg::OP_LOOKUP && count_r != '0) begin
            q_pop     = 1'b1;
            rd_issue  = 1'b1;
            lo_nxt    = '0;
            hi_nxt    = count_r;
            mid_nxt   = start_half[IDX_W-1:0];
            query_nxt = q_item.query;
            state_nxt = S_SEARCH;
          end else if (slot_free) begin
            q_pop    = 1'b1;
            imm_load = 1'b1;
            case (q_item.op)
              hatfl_pkg::OP_BYTE: begin
                if (closed_r || err_r) begin
                  imm_status = hatfl_pkg::ST_REFUSED;
                end else if (q_item.is_newline) begin
                  if (len_r == '0) begin
                    closed_nxt = 1'b1;
                  end else begin
                    do_commit = 1'b1;
                  end
                end else begin
                  if (len_r < LEN_W'(ADDRESS_DIGITS)) begin
                    partial_nxt = shifted[ADR_W-1:0];
                    if (!q_item.digit_ok) begin
                      bad_nxt = 1'b1;
                    end
                  end
                  if (len_inc >= LEN_W'(LINE_LIMIT)) begin
                    err_nxt     = 1'b1;
                    len_nxt     = '0;
                    partial_nxt = '0;
                    bad_nxt     = 1'b0;
                    imm_status  = hatfl_pkg::ST_LONG;
                  end else begin
                    len_nxt = len_inc;
                  end
                end
              end
              hatfl_pkg::OP_EOF: begin
                if (closed_r || err_r) begin
                  imm_status = hatfl_pkg::ST_REFUSED;
                end else begin
                  if (len_r != '0) begin
                    do_commit = 1'b1;
                  end
                  closed_nxt = 1'b1;
                end
              end
              hatfl_pkg::OP_LOOKUP: begin
                // empty table
                imm_status = hatfl_pkg::ST_NOTFOUND;
              end
              default: begin
                count_nxt   = '0;
                len_nxt     = '0;
                partial_nxt = '0;
                bad_nxt     = 1'b0;
                closed_nxt  = 1'b0;
                err_nxt     = 1'b0;
              end
            endcase
            if (do_commit) begin
              imm_status = commit_st;
              if (commit_st == hatfl_pkg::ST_COMMIT) begin
                we        = 1'b1;
                imm_row   = count_r[IDX_W-1:0];
                count_nxt = count_r + 1'b1;
              end else begin
                err_nxt = 1'b1;
              end
              len_nxt     = '0;
              partial_nxt = '0;
              bad_nxt     = 1'b0;
            end
          end
        end
      end
      S_SEARCH: begin
        lo_nxt = lo_n;
        hi_nxt = hi_n;
        if (lo_n < hi_n) begin
          rd_issue = 1'b1;
          rd_addr  = step_half[IDX_W-1:0];
          mid_nxt  = step_half[IDX_W-1:0];
        end else begin
          state_nxt = S_DONE;
          if (lo_n == '0) begin
            res_status_nxt = hatfl_pkg::ST_NOTFOUND;
            res_row_nxt    = '0;
          end else begin
            res_status_nxt = hatfl_pkg::ST_FOUND;
            res_row_nxt    = below_lo[IDX_W-1:0];
          end
        end
      end
      S_DONE: begin
        if (slot_free) begin
          imm_load   = 1'b1;
          imm_status = res_status_r;
          imm_row    = res_row_r;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_row_nxt    = out_row_r;
    out_rows_nxt   = out_rows_r;
    if (imm_load) begin
      out_valid_nxt  = 1'b1;
      out_status_nxt = imm_status;
      out_row_nxt    = imm_row;
      out_rows_nxt   = count_nxt;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      len_r       <= '0;
      partial_r   <= '0;
      bad_r       <= 1'b0;
      closed_r    <= 1'b0;
      err_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      len_r       <= len_nxt;
      partial_r   <= partial_nxt;
      bad_r       <= bad_nxt;
      closed_r    <= closed_nxt;
      err_r       <= err_nxt;
      out_valid_r <= out_valid_nxt;
    end
    lo_r         <= lo_nxt;
    hi_r         <= hi_nxt;
    mid_r        <= mid_nxt;
    query_r      <= query_nxt;
    res_status_r <= res_status_nxt;
    res_row_r    <= res_row_nxt;
    out_status_r <= out_status_nxt;
    out_row_r    <= out_row_nxt;
    out_rows_r   <= out_rows_nxt;
  end

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      table_mem[count_r[IDX_W-1:0]] <= partial_r;
    end
    rdata_r <= table_mem[rd_addr];
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_row_index   = out_row_r;
  assign out_rows_loaded = out_rows_r;

  `AST_IMPLIES(a_search_open, clk, rst_n, state_r == S_SEARCH, lo_r < hi_r)
  `AST_IMPLIES(a_probe_in_rows, clk, rst_n, rd_issue, CNT_W'(rd_addr) < count_r)
  `AST_IMPLIES(a_write_room, clk, rst_n, we, count_r < CNT_W'(TABLE_DEPTH))
  `AST_IMPLIES(a_pop_idle, clk, rst_n, q_pop, state_r == S_IDLE && q_valid)

endmodule

// ===== design/hex_address_table_floor_lookup_unit.sv =====
`timescale 1ns / 1ps
// channel   handshake          payload
// in        in_valid/in_stall  in_action, in_text_byte, in_query_address
// out       out_valid/out_stall out_status, out_row_index, out_rows_loaded
//
// load byte, end of file and clear: one item per cycle sustained unless out_stall holds the result
// lookup: one probe per cycle, at most ceil(log2(rows+1)) probes;
//   the probe loop runs through the table read port (address from the last compare)
// reset clears control state; the table itself has no reset and no clearing pass
// a two-item queue takes input while the back end works; in_stall rises when it is full
// out_stall holds the result register and the back end waits for it

module hex_address_table_floor_lookup_unit #(
  parameter int TABLE_DEPTH    = 8192,
  parameter int LINE_LIMIT     = 128,
  parameter int ADDRESS_DIGITS = 8
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [1:0]                         in_action,
  input  logic [hatfl_pkg::BYTE_W-1:0]       in_text_byte,
  input  logic [hatfl_pkg::QUERY_W-1:0]      in_query_address,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [hatfl_pkg::STATUS_W-1:0]     out_status,
  output logic [$clog2(TABLE_DEPTH)-1:0]     out_row_index,
  output logic [$clog2(TABLE_DEPTH+1)-1:0]   out_rows_loaded
);

  logic             q_valid;
  logic             q_pop;
  hatfl_pkg::item_t q_item;

  hatfl_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_action        (in_action),
    .in_text_byte     (in_text_byte),
    .in_query_address (in_query_address),
    .q_valid          (q_valid),
    .q_item           (q_item),
    .q_pop            (q_pop)
  );

  hatfl_back #(
    .TABLE_DEPTH    (TABLE_DEPTH),
    .LINE_LIMIT     (LINE_LIMIT),
    .ADDRESS_DIGITS (ADDRESS_DIGITS)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid         (q_valid),
    .q_item          (q_item),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_row_index   (out_row_index),
    .out_rows_loaded (out_rows_loaded)
  );

endmodule
